[rtl/core/first_fit_block_allocator_unit_defines.svh]
// Assertion helpers shared by the allocator RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, held off while reset is low.
`define FFBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ffba_pkg.sv]
`timescale 1ns / 1ps

package ffba_pkg;

    localparam logic [31:0] HEAP_BASE_RESET = 32'h0020_0000;
    localparam logic [6:0]  HEADER_RESET    = 7'd24;
    localparam logic [6:0]  HEADER_MAX      = 7'd64;
    localparam logic [6:0]  HEADER_MIN      = 7'd1;

    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_FREE   = 2'd1;
    localparam logic [1:0] KIND_RESIZE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NULL    = 2'd1;
    localparam logic [1:0] ST_SPACE   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic REG_HEAP_BASE = 1'b0;
    localparam logic REG_HEADER    = 1'b1;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] size;
    } t_req;

    typedef struct packed {
        logic        valid;
        logic        fit_found;
        logic [31:0] fit_addr;
        logic        match_found;
        logic [31:0] match_size;
    } t_rec;

    typedef struct packed {
        logic        take_fit;
        logic        free_match;
        logic        append;
        logic [31:0] append_addr;
        logic [31:0] append_size;
    } t_cmd;

endpackage

[rtl/core/ffba_cell.sv]
`timescale 1ns / 1ps

module ffba_cell import ffba_pkg::*; #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_req          i_req,
    input  logic [CW-1:0] i_count,
    input  t_cmd          i_cmd,
    input  t_rec          i_chain,
    output t_rec          o_chain
);

    logic [31:0] r_addr;
    logic [31:0] r_size;
    logic        r_free;
    logic        r_fit_sel;
    logic        r_match_sel;
    t_rec        r_out;
    t_rec        n_out;

    logic live;
    logic fits;
    logic hit;
    logic take_fit_here;
    logic take_match_here;

    assign live            = CW'(IDX) < i_count;
    assign fits            = live && r_free && (r_size >= i_req.size);
    assign hit             = live && (r_addr == i_req.addr);
    assign take_fit_here   = i_chain.valid && fits && !i_chain.fit_found;
    assign take_match_here = i_chain.valid && hit && !i_chain.match_found;

    always_comb begin
        n_out             = i_chain;
        n_out.fit_found   = i_chain.fit_found | take_fit_here;
        n_out.fit_addr    = take_fit_here ? r_addr : i_chain.fit_addr;
        n_out.match_found = i_chain.match_found | take_match_here;
        n_out.match_size  = take_match_here ? r_size : i_chain.match_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out       <= '0;
            r_fit_sel   <= 1'b0;
            r_match_sel <= 1'b0;
        end else begin
            r_out <= n_out;
            if (i_chain.valid) begin
                r_fit_sel   <= take_fit_here;
                r_match_sel <= take_match_here;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && (i_count == CW'(IDX))) begin
            r_addr <= i_cmd.append_addr;
            r_size <= i_cmd.append_size;
            r_free <= 1'b0;
        end else if (i_cmd.take_fit && r_fit_sel) begin
            r_free <= 1'b0;
        end else if (i_cmd.free_match && r_match_sel) begin
            r_free <= 1'b1;
        end
    end

    assign o_chain = r_out;

endmodule

[rtl/core/ffba_chain.sv]
`timescale 1ns / 1ps

module ffba_chain import ffba_pkg::*; #(
    parameter int MAX_BLOCKS = 64,
    parameter int CW         = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_req          i_req,
    input  logic [CW-1:0] i_count,
    input  t_cmd          i_cmd,
    input  t_rec          i_chain,
    output t_rec          o_chain
);

    t_rec w_link [MAX_BLOCKS+1];

    assign w_link[0] = i_chain;

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffba_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (i_req),
            .i_count (i_count),
            .i_cmd   (i_cmd),
            .i_chain (w_link[g]),
            .o_chain (w_link[g+1])
        );
    end

    assign o_chain = w_link[MAX_BLOCKS];

endmodule

[rtl/core/first_fit_block_allocator_unit.sv]
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// request   start / busy              i_kind, i_address, i_size
// result    o_valid (one-cycle pulse) o_result_address, o_status, o_copy_source, o_copy_length
// config    i_cfg_we                  i_cfg_index, i_cfg_data
//
// The search token walks the cell chain one cell per cycle; a new request is
// taken only once the scan of the last one has ended and busy has fallen.
// The result registers capture the outcome at the scan end, and o_valid is registered from it.
// Reset is synchronous and active low; the block table is not cleared, only the count and the used-byte offset.
// The result is never held off: o_valid lasts one cycle and must be taken.

`include "first_fit_block_allocator_unit_defines.svh"

module first_fit_block_allocator_unit import ffba_pkg::*; #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_address,
    input  logic [31:0] i_size,
    output logic        o_valid,
    output logic [31:0] o_result_address,
    output logic [1:0]  o_status,
    output logic [31:0] o_copy_source,
    output logic [31:0] o_copy_length,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LAUNCH = 3'b010,
        S_SCAN   = 3'b100
    } t_state;

    t_state      r_state;
    logic [31:0] r_heap_base;
    logic [6:0]  r_header;
    logic [1:0]  r_kind;
    t_req        r_req;
    logic [33:0] r_hdr;
    logic [33:0] r_pay;
    logic [32:0] r_grow;
    logic [CW-1:0] r_count;
    logic [32:0] r_used;
    logic        r_valid;
    logic [31:0] r_result_address;
    logic [1:0]  r_status;
    logic [31:0] r_copy_source;
    logic [31:0] r_copy_length;

    logic [6:0]  eff_h;
    logic        accept;
    logic        commit;
    t_rec        chain_in;
    t_rec        chain_out;
    t_cmd        cmd;
    logic        alloc_path;
    logic        move;
    logic        need_grab;
    logic [34:0] end_addr;
    logic        room;
    logic        full;
    logic        grab_fit;
    logic        grab_app;
    logic        grab_ok;
    logic [31:0] grab_addr;
    logic [31:0] n_result_address;
    logic [1:0]  n_status;
    logic [31:0] n_copy_source;
    logic [31:0] n_copy_length;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign commit = (r_state == S_SCAN) && chain_out.valid;

    always_comb begin
        if (r_header == 7'd0) begin
            eff_h = HEADER_MIN;
        end else if (r_header > HEADER_MAX) begin
            eff_h = HEADER_MAX;
        end else begin
            eff_h = r_header;
        end
    end

    always_comb begin
        chain_in       = '0;
        chain_in.valid = (r_state == S_LAUNCH);
    end

    assign alloc_path = (r_kind == KIND_ALLOC) ||
                        ((r_kind == KIND_RESIZE) && (r_req.addr == 32'd0));
    assign move       = (r_kind == KIND_RESIZE) && (r_req.addr != 32'd0) &&
                        chain_out.match_found && (chain_out.match_size < r_req.size);
    assign need_grab  = (alloc_path && (r_req.size != 32'd0)) || move;
    assign end_addr   = {1'b0, r_pay} + {3'b000, r_req.size};
    assign room       = (end_addr <= 35'h1_0000_0000);
    assign full       = (r_count >= CW'(MAX_BLOCKS));
    assign grab_fit   = need_grab && chain_out.fit_found;
    assign grab_app   = need_grab && !chain_out.fit_found && !full && room;
    assign grab_ok    = grab_fit || grab_app;
    assign grab_addr  = chain_out.fit_found ? chain_out.fit_addr : r_pay[31:0];

    always_comb begin
        n_result_address = 32'd0;
        n_status         = ST_OK;
        n_copy_source    = 32'd0;
        n_copy_length    = 32'd0;
        unique case (r_kind)
            KIND_ALLOC: begin
                if (r_req.size == 32'd0) begin
                    n_status = ST_NULL;
                end else if (grab_ok) begin
                    n_result_address = grab_addr;
                end else begin
                    n_status = ST_SPACE;
                end
            end
            KIND_FREE: begin
                if ((r_req.addr != 32'd0) && !chain_out.match_found) begin
                    n_status = ST_UNKNOWN;
                end
            end
            KIND_RESIZE: begin
                if (r_req.addr == 32'd0) begin
                    if (r_req.size == 32'd0) begin
                        n_status = ST_NULL;
                    end else if (grab_ok) begin
                        n_result_address = grab_addr;
                    end else begin
                        n_status = ST_SPACE;
                    end
                end else if (!chain_out.match_found) begin
                    n_status = ST_UNKNOWN;
                end else if (!move) begin
                    n_result_address = r_req.addr;
                end else if (grab_ok) begin
                    n_result_address = grab_addr;
                    n_copy_source    = r_req.addr;
                    n_copy_length    = chain_out.match_size;
                end else begin
                    n_status = ST_SPACE;
                end
            end
            default: begin
                n_status = ST_NULL;
            end
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.take_fit    = commit && grab_fit;
        cmd.append      = commit && grab_app;
        cmd.free_match  = commit && (((r_kind == KIND_FREE) && (r_req.addr != 32'd0) &&
                                      chain_out.match_found) || (move && grab_ok));
        cmd.append_addr = r_pay[31:0];
        cmd.append_size = r_req.size;
    end

    ffba_chain #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .CW         (CW)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_count (r_count),
        .i_cmd   (cmd),
        .i_chain (chain_in),
        .o_chain (chain_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_heap_base <= HEAP_BASE_RESET;
            r_header    <= HEADER_RESET;
            r_count     <= '0;
            r_used      <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= commit;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_HEAP_BASE: r_heap_base <= i_cfg_data;
                    REG_HEADER:    r_header    <= i_cfg_data[6:0];
                    default:       r_header    <= r_header;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_LAUNCH;
                    end
                end
                S_LAUNCH: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (commit) begin
                        r_state <= S_IDLE;
                        if (grab_app) begin
                            r_count <= CW'(r_count + 1'b1);
                            r_used  <= 33'({1'b0, r_used} + {1'b0, r_grow});
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind     <= i_kind;
            r_req.addr <= i_address;
            r_req.size <= i_size;
            r_hdr      <= {2'b00, r_heap_base} + {1'b0, r_used};
        end
        if (r_state == S_LAUNCH) begin
            r_grow <= {1'b0, r_req.size} + 33'(eff_h);
        end
        if (r_state != S_IDLE) begin
            r_pay <= r_hdr + 34'(eff_h);
        end
        if (commit) begin
            r_result_address <= n_result_address;
            r_status         <= n_status;
            r_copy_source    <= n_copy_source;
            r_copy_length    <= n_copy_length;
        end
    end

    assign o_valid          = r_valid;
    assign o_result_address = r_result_address;
    assign o_status         = r_status;
    assign o_copy_source    = r_copy_source;
    assign o_copy_length    = r_copy_length;

    `FFBA_ASSERT_NEXT(a_commit_strobe, i_clk, i_rst_n, commit, o_valid && !busy,
        "result strobe missing after scan end")
    `FFBA_ASSERT_NOW(a_one_update, i_clk, i_rst_n, cmd.append, !cmd.take_fit,
        "append and reuse in the same request")
    `FFBA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_BLOCKS),
        "block count beyond table depth")
    `FFBA_ASSERT_NEXT(a_launch, i_clk, i_rst_n, accept, r_state == S_LAUNCH && !o_valid,
        "request transfer did not launch a scan")

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ffba_pkg::*;

    localparam int SLOTS = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam logic [1:0] KIND_UNDEF = 2'd3;

    typedef struct packed {
        logic [31:0] addr;
        logic [1:0]  status;
        logic [31:0] src;
        logic [31:0] len;
    } grant_t;

    class heap_ledger;
        logic [31:0] base_addr;
        logic [6:0]  hdr_reg;
        logic [31:0] blk_addr [SLOTS];
        logic [31:0] blk_size [SLOTS];
        bit          blk_free [SLOTS];
        int          blk_count;
        logic [32:0] used_bytes;
        logic [31:0] last_addr;
        grant_t      due_grants [$];
        int          fault_count;

        function new();
            base_addr   = HEAP_BASE_RESET;
            hdr_reg     = HEADER_RESET;
            blk_count   = 0;
            used_bytes  = '0;
            last_addr   = '0;
            fault_count = 0;
        endfunction

        function logic [31:0] hdr_len();
            if (hdr_reg < HEADER_MIN) return 32'(HEADER_MIN);
            if (hdr_reg > HEADER_MAX) return 32'(HEADER_MAX);
            return 32'(hdr_reg);
        endfunction

        // first fit among free blocks, else append after the bump offset
        function logic [31:0] take_block(logic [31:0] size);
            logic [63:0] hdr_at;
            logic [63:0] end_at;
            for (int i = 0; i < blk_count; i++) begin
                if (blk_free[i] && blk_size[i] >= size) begin
                    blk_free[i] = 1'b0;
                    return blk_addr[i];
                end
            end
            if (blk_count >= SLOTS) return '0;
            hdr_at = 64'(base_addr) + 64'(used_bytes);
            end_at = hdr_at + 64'(hdr_len()) + 64'(size);
            if (end_at > 64'h1_0000_0000) return '0;
            blk_addr[blk_count] = 32'(hdr_at + 64'(hdr_len()));
            blk_size[blk_count] = size;
            blk_free[blk_count] = 1'b0;
            blk_count++;
            used_bytes = 33'(used_bytes + 33'(hdr_len()) + 33'(size));
            return blk_addr[blk_count - 1];
        endfunction

        function int find_block(logic [31:0] addr);
            for (int i = 0; i < blk_count; i++) begin
                if (blk_addr[i] == addr) return i;
            end
            return -1;
        endfunction

        function grant_t allocate(logic [31:0] size);
            grant_t g;
            g = '0;
            if (size == 0) begin
                g.status = ST_NULL;
                return g;
            end
            g.addr   = take_block(size);
            g.status = (g.addr != 0) ? ST_OK : ST_SPACE;
            return g;
        endfunction

        function void book_request(logic [1:0] kind, logic [31:0] addr, logic [31:0] size);
            grant_t      g;
            int          idx;
            logic [31:0] moved;
            g = '0;
            case (kind)
                KIND_ALLOC: g = allocate(size);
                KIND_FREE: begin
                    if (addr != 0) begin
                        idx = find_block(addr);
                        if (idx < 0) g.status = ST_UNKNOWN;
                        else blk_free[idx] = 1'b1;
                    end
                end
                KIND_RESIZE: begin
                    if (addr == 0) begin
                        g = allocate(size);
                    end else begin
                        idx = find_block(addr);
                        if (idx < 0) begin
                            g.status = ST_UNKNOWN;
                        end else if (blk_size[idx] >= size) begin
                            g.addr = addr;
                        end else begin
                            moved = take_block(size);
                            if (moved == 0) begin
                                g.status = ST_SPACE;
                            end else begin
                                g.addr = moved;
                                g.src  = addr;
                                g.len  = blk_size[idx];
                                blk_free[idx] = 1'b1;
                            end
                        end
                    end
                end
                default: g.status = ST_NULL;
            endcase
            last_addr = g.addr;
            due_grants.push_back(g);
        endfunction

        function void match_result(grant_t got);
            grant_t want;
            if (due_grants.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: addr %h status %0d src %h len %h",
                             got.addr, got.status, got.src, got.len);
                return;
            end
            want = due_grants.pop_front();
            if (got.addr !== want.addr || got.status !== want.status ||
                got.src !== want.src || got.len !== want.len) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("mismatch: expected addr %h status %0d src %h len %h, got addr %h status %0d src %h len %h",
                             want.addr, want.status, want.src, want.len,
                             got.addr, got.status, got.src, got.len);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_kind;
    logic [31:0] i_address;
    logic [31:0] i_size;
    logic        o_valid;
    logic [31:0] o_result_address;
    logic [1:0]  o_status;
    logic [31:0] o_copy_source;
    logic [31:0] o_copy_length;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    heap_ledger ledger;
    int         quiet_cycles = 0;
    int         calm_left = 0;

    first_fit_block_allocator_unit #(
        .MAX_BLOCKS(SLOTS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_address       (i_address),
        .i_size          (i_size),
        .o_valid         (o_valid),
        .o_result_address(o_result_address),
        .o_status        (o_status),
        .o_copy_source   (o_copy_source),
        .o_copy_length   (o_copy_length),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            ledger.match_result(grant_t'{o_result_address, o_status, o_copy_source, o_copy_length});
    end

    initial begin
        @(posedge i_clk);
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("tb failed");
        $finish;
    end

    function automatic logic [31:0] rand_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return $urandom_range(1, 64);
        if (roll < 80) return $urandom_range(65, 2048);
        if (roll < 88) return '0;
        if (roll < 95) return $urandom();
        return 32'hFFFF_FFFF - $urandom_range(0, 255);
    endfunction

    function automatic logic [31:0] known_addr();
        int roll;
        roll = $urandom_range(0, 99);
        if (ledger.blk_count == 0 || roll >= 96) return $urandom();
        if (roll >= 92) return '0;
        return ledger.blk_addr[$urandom_range(0, ledger.blk_count - 1)];
    endfunction

    task automatic send(logic [1:0] kind, logic [31:0] addr, logic [31:0] size);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else if (roll < 3) begin
            calm_left = $urandom_range(10, 40);
            gap = 0;
        end else if (roll < 45) begin
            gap = 0;
        end else if (roll < 80) begin
            gap = $urandom_range(1, 6);
        end else if (roll < 95) begin
            gap = $urandom_range(7, 60);
        end else begin
            gap = $urandom_range(61, 200);
        end
        if (gap > 0) begin
            start     <= 1'b0;
            i_kind    <= 2'($urandom());
            i_address <= $urandom();
            i_size    <= $urandom();
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_kind    <= kind;
        i_address <= addr;
        i_size    <= size;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ledger.book_request(kind, addr, size);
    endtask

    task automatic set_config(logic [31:0] base, logic [31:0] hdr_word);
        start <= 1'b0;
        @(posedge i_clk);
        while (ledger.due_grants.size() != 0 || busy) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_HEAP_BASE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        ledger.base_addr = base;
        i_cfg_index <= REG_HEADER;
        i_cfg_data  <= hdr_word;
        @(posedge i_clk);
        ledger.hdr_reg = hdr_word[6:0];
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_traffic(int count);
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] size;
        int          roll;
        int          idx;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            kind = KIND_ALLOC;
            addr = known_addr();
            size = rand_size();
            if (roll < 40) begin
                kind = KIND_ALLOC;
            end else if (roll < 65) begin
                kind = KIND_FREE;
            end else if (roll < 90) begin
                kind = KIND_RESIZE;
                if (roll < 78 && ledger.blk_count > 0) begin
                    idx  = $urandom_range(0, ledger.blk_count - 1);
                    addr = ledger.blk_addr[idx];
                    size = $urandom_range(0, ledger.blk_size[idx]);
                end
            end else begin
                case ($urandom_range(0, 4))
                    0: begin
                        kind = KIND_UNDEF;
                        addr = $urandom();
                        size = $urandom();
                    end
                    1: begin
                        kind = KIND_FREE;
                        addr = '0;
                    end
                    2: begin
                        kind = KIND_RESIZE;
                        addr = '0;
                    end
                    3: begin
                        kind = KIND_FREE;
                        addr = $urandom();
                    end
                    default: begin
                        kind = KIND_RESIZE;
                        addr = known_addr() + 32'd1;
                    end
                endcase
            end
            send(kind, addr, size);
        end
    endtask

    initial begin
        logic [31:0] blk_a;
        logic [31:0] blk_b;
        logic [31:0] blk_c;
        logic [31:0] base;
        logic [31:0] hdr_word;

        ledger      = new();
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_kind      <= KIND_ALLOC;
        i_address   <= '0;
        i_size      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_HEAP_BASE;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(KIND_ALLOC, 32'h0, 32'h0);
        send(KIND_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(KIND_FREE, 32'h0, 32'h5);
        send(KIND_FREE, 32'h1234_5678, 32'h0);
        send(KIND_RESIZE, 32'hDEAD_BEEF, 32'h10);
        send(KIND_ALLOC, 32'h0, 32'd100);
        blk_a = ledger.last_addr;
        send(KIND_ALLOC, 32'h0, 32'd1);
        blk_b = ledger.last_addr;
        send(KIND_ALLOC, 32'h0, 32'hFFFF_FFFF);
        send(KIND_FREE, blk_a, 32'h0);
        send(KIND_FREE, blk_a, 32'h0);
        send(KIND_ALLOC, 32'h0, 32'd50);
        send(KIND_RESIZE, blk_a, 32'd100);
        send(KIND_RESIZE, blk_a, 32'd0);
        send(KIND_RESIZE, blk_b, 32'd500);
        blk_c = ledger.last_addr;
        send(KIND_RESIZE, 32'h0, 32'd40);
        send(KIND_RESIZE, blk_c, 32'hFFFF_FFF0);
        send(KIND_RESIZE, 32'h0, 32'h0);

        set_config(32'hFFFF_FFFF, 32'd127);
        send(KIND_ALLOC, 32'h0, 32'd1000);
        send(KIND_RESIZE, blk_c, 32'd2000);

        // place the top of the address space exactly at the end of the next block
        set_config(32'(33'h1_0000_0000 - ledger.used_bytes - 33'd264), 32'd64);
        send(KIND_ALLOC, 32'h0, 32'd200);
        send(KIND_ALLOC, 32'h0, 32'd300);

        set_config(32'h0, 32'h0);
        send(KIND_ALLOC, 32'h0, 32'd1000);
        send(KIND_ALLOC, 32'h0, 32'd7);

        set_config($urandom(), 32'hFFFF_FF41);

        for (int p = 0; p < 5; p++) begin
            case ($urandom_range(0, 5))
                0: hdr_word = 32'd0;
                1: hdr_word = 32'd1;
                2: hdr_word = 32'd24;
                3: hdr_word = 32'd64;
                4: hdr_word = 32'd127;
                default: hdr_word = ($urandom() & 32'hFFFF_FF80) | $urandom_range(0, 127);
            endcase
            base = $urandom_range(0, 1) ? HEAP_BASE_RESET : $urandom_range(0, 32'h7FFF_FFFF);
            set_config(base, hdr_word);
            random_traffic(220);
        end

        start <= 1'b0;
        while (ledger.due_grants.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);
        if (ledger.fault_count == 0 && ledger.due_grants.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
